// ----- hw/rtl/nested_page_table_walk_build_macros.svh -----
// Assertion macros for the page table walker.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef NESTED_PAGE_TABLE_WALK_BUILD_MACROS_SVH
`define NESTED_PAGE_TABLE_WALK_BUILD_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NPW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define NPW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NPW_ASSERT_IMP(label, ante, cons, msg)
`define NPW_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/npw_pkg.sv -----
// Shared constants, codes and the level index helper for the page table walker.
// No dependencies.
package npw_pkg;

  localparam int POOL_PAGES = 64;
  localparam int ADDR_BITS  = 48;

  localparam int SLOT_W      = 9;
  localparam int LEAF_SHIFT  = 12;
  localparam int LEVELS      = 4;
  localparam int LVL_W       = 2;
  localparam int FRAME_W     = 36;
  localparam int ENTRY_W     = FRAME_W + 1;
  localparam int USABLE_W    = 7;
  localparam int LEAF_PAGE_W = 6;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;

  localparam int PAGE_W   = $clog2(POOL_PAGES);
  localparam int COUNT_W  = $clog2(POOL_PAGES + 1);
  localparam int MEM_AW   = PAGE_W + SLOT_W;
  localparam int MEM_DEPTH = POOL_PAGES * (1 << SLOT_W);

  localparam logic [LVL_W-1:0] LEAF_LEVEL = LVL_W'(LEVELS - 1);

  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE = CFG_IDX_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_EXHAUSTED = 2'd2
  } npw_status_t;

  // level 0 is the root (top index bits), level 3 the leaf
  function automatic logic [SLOT_W-1:0] lvl_index(input logic [ADDR_BITS-1:0] addr,
                                                  input logic [LVL_W-1:0] lvl);
    logic [ADDR_BITS-1:0] sh;
    sh = addr >> (LEAF_SHIFT + SLOT_W * (LEVELS - 1 - int'(lvl)));
    return sh[SLOT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/nested_page_table_walk_build.sv -----
// Four-level page table walker with find and build over a pool of table pages.
// A walk is the accept in S_IDLE, then four table reads, each an address state
// (S_RD) and an evaluate state (S_EVAL), on the one port of the table RAM, with link
// allocation or the leaf write done in the evaluate state, then S_DONE, which loads
// the output register; no new item is accepted until the walk is back in S_IDLE.
// A walk may instead end at a link level, with a missing link or an exhausted pool.
// While an earlier result is still stalled in the output register, the finished walk
// waits in S_DONE. After reset a clearing pass writes zero to all 32768 table
// entries, one per cycle, and no item is accepted until it ends; configuration
// writes are taken at any time. Depends on npw_pkg, npw_ram and the macros header.
`include "nested_page_table_walk_build_macros.svh"

module nested_page_table_walk_build (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_opcode,
  input  logic [npw_pkg::ADDR_BITS-1:0]          in_phys_addr,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [npw_pkg::STATUS_W-1:0]           out_status,
  output logic [npw_pkg::LEAF_PAGE_W-1:0]        out_leaf_table_page,
  output logic [npw_pkg::SLOT_W-1:0]             out_leaf_slot,
  output logic                                   out_leaf_valid,
  output logic [npw_pkg::FRAME_W-1:0]            out_leaf_frame,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [npw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [npw_pkg::FRAME_W-1:0]            cfg_data
);
  import npw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [MEM_AW-1:0]       clr_r, clr_nxt;
  logic                    op_r, op_nxt;
  logic [ADDR_BITS-1:0]    addr_r, addr_nxt;
  logic [PAGE_W-1:0]       page_r, page_nxt;
  logic [LVL_W-1:0]        level_r, level_nxt;
  logic [COUNT_W-1:0]      pages_used_r, pages_used_nxt;
  logic [FRAME_W-1:0]      base_r, base_nxt;
  logic [USABLE_W-1:0]     usable_r, usable_nxt;

  npw_status_t             res_status_r, res_status_nxt;
  logic [LEAF_PAGE_W-1:0]  res_page_r, res_page_nxt;
  logic [SLOT_W-1:0]       res_slot_r, res_slot_nxt;
  logic                    res_valid_r, res_valid_nxt;
  logic [FRAME_W-1:0]      res_frame_r, res_frame_nxt;

  logic                    out_valid_r, out_valid_nxt;
  npw_status_t             out_status_r, out_status_nxt;
  logic [LEAF_PAGE_W-1:0]  out_page_r, out_page_nxt;
  logic [SLOT_W-1:0]       out_slot_r, out_slot_nxt;
  logic                    out_lvalid_r, out_lvalid_nxt;
  logic [FRAME_W-1:0]      out_frame_r, out_frame_nxt;

  logic                    mem_we;
  logic [MEM_AW-1:0]       mem_addr;
  logic [ENTRY_W-1:0]      mem_wdata;
  logic [ENTRY_W-1:0]      mem_rdata;

  logic [SLOT_W-1:0]       slot;
  logic                    entry_valid;
  logic [FRAME_W-1:0]      entry_frame;
  logic [FRAME_W-1:0]      rel;
  logic [COUNT_W-1:0]      limit;

  // Each write of an item goes to the entry it has just read, and lands before any later
  // read is issued, so no forwarding is needed.
  npw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign slot        = lvl_index(addr_r, level_r);
  assign entry_valid = mem_rdata[FRAME_W];
  assign entry_frame = mem_rdata[FRAME_W-1:0];
  assign rel         = entry_frame - base_r;

  always_comb begin
    if (usable_r == '0 || int'(usable_r) > POOL_PAGES) begin
      limit = COUNT_W'(POOL_PAGES);
    end else begin
      limit = COUNT_W'(usable_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    page_nxt       = page_r;
    level_nxt      = level_r;
    pages_used_nxt = pages_used_r;
    base_nxt       = base_r;
    usable_nxt     = usable_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_slot_nxt   = res_slot_r;
    res_valid_nxt  = res_valid_r;
    res_frame_nxt  = res_frame_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_slot_nxt   = out_slot_r;
    out_lvalid_nxt = out_lvalid_r;
    out_frame_nxt  = out_frame_r;
    mem_we         = 1'b0;
    mem_wdata      = '0;
    mem_addr       = (state_r == S_CLEAR) ? clr_r : {page_r, slot};

    if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE:   base_nxt   = cfg_data;
        CFG_USABLE: usable_nxt = cfg_data[USABLE_W-1:0];
        default:    ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          addr_nxt  = in_phys_addr;
          page_nxt  = '0;
          level_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (level_r == LEAF_LEVEL) begin
          res_status_nxt = ST_OK;
          res_page_nxt   = LEAF_PAGE_W'(page_r);
          res_slot_nxt   = slot;
          if (op_r == OP_BUILD) begin
            mem_we        = 1'b1;
            mem_wdata     = {1'b1, FRAME_W'(addr_r >> LEAF_SHIFT)};
            res_valid_nxt = 1'b1;
            res_frame_nxt = FRAME_W'(addr_r >> LEAF_SHIFT);
          end else begin
            res_valid_nxt = entry_valid;
            res_frame_nxt = entry_frame;
          end
          state_nxt = S_DONE;
        end else begin
          res_page_nxt  = '0;
          res_slot_nxt  = '0;
          res_valid_nxt = 1'b0;
          res_frame_nxt = '0;
          if (entry_valid) begin
            // link must point inside the pages handed out so far
            if (rel >= FRAME_W'(pages_used_r)) begin
              res_status_nxt = ST_MISSING;
              state_nxt      = S_DONE;
            end else begin
              page_nxt  = rel[PAGE_W-1:0];
              level_nxt = level_r + 1'b1;
              state_nxt = S_RD;
            end
          end else if (op_r == OP_FIND) begin
            res_status_nxt = ST_MISSING;
            state_nxt      = S_DONE;
          end else if (pages_used_r >= limit) begin
            res_status_nxt = ST_EXHAUSTED;
            state_nxt      = S_DONE;
          end else begin
            // fresh page is still zero from the clearing pass: never written since
            mem_we         = 1'b1;
            mem_wdata      = {1'b1, base_r + FRAME_W'(pages_used_r)};
            page_nxt       = pages_used_r[PAGE_W-1:0];
            pages_used_nxt = pages_used_r + 1'b1;
            level_nxt      = level_r + 1'b1;
            state_nxt      = S_RD;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_page_nxt   = res_page_r;
          out_slot_nxt   = res_slot_r;
          out_lvalid_nxt = res_valid_r;
          out_frame_nxt  = res_frame_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      pages_used_r <= COUNT_W'(1);
      base_r       <= '0;
      usable_r     <= USABLE_W'(64);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      pages_used_r <= pages_used_nxt;
      base_r       <= base_nxt;
      usable_r     <= usable_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    page_r       <= page_nxt;
    level_r      <= level_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_slot_r   <= res_slot_nxt;
    res_valid_r  <= res_valid_nxt;
    res_frame_r  <= res_frame_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_slot_r   <= out_slot_nxt;
    out_lvalid_r <= out_lvalid_nxt;
    out_frame_r  <= out_frame_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_leaf_table_page = out_page_r;
  assign out_leaf_slot       = out_slot_r;
  assign out_leaf_valid      = out_lvalid_r;
  assign out_leaf_frame      = out_frame_r;

  `NPW_ASSERT_IMP(a_pages_cap, 1'b1, int'(pages_used_r) <= POOL_PAGES, "pool count overrun")
  `NPW_ASSERT_NXT(a_pages_mono, 1'b1, pages_used_r >= $past(pages_used_r), "pool count shrank")
  `NPW_ASSERT_NXT(a_accept_walk, in_valid && !in_stall, state_r == S_RD, "accept did not start walk")
  `NPW_ASSERT_IMP(a_fail_zero, out_valid_r && out_status_r != ST_OK,
                  out_lvalid_r == 1'b0 && out_frame_r == '0, "failed item carries leaf data")
  `NPW_ASSERT_IMP(a_write_owned, mem_we && state_r != S_CLEAR,
                  COUNT_W'(mem_addr[MEM_AW-1:SLOT_W]) < pages_used_r, "write to unowned page")

endmodule

// ----- hw/rtl/npw_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module npw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- verif/nested_page_table_walk_build_chk.sv -----
`timescale 1ns / 100ps
// Checker for the page table walker: mirrors the table store, pool counter and
// registers, predicts each walk result and compares results in order. Uses npw_pkg.
module nested_page_table_walk_build_chk (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_opcode,
  input  logic [npw_pkg::ADDR_BITS-1:0]   in_phys_addr,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [npw_pkg::STATUS_W-1:0]    out_status,
  input  logic [npw_pkg::LEAF_PAGE_W-1:0] out_leaf_table_page,
  input  logic [npw_pkg::SLOT_W-1:0]      out_leaf_slot,
  input  logic                            out_leaf_valid,
  input  logic [npw_pkg::FRAME_W-1:0]     out_leaf_frame,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [npw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [npw_pkg::FRAME_W-1:0]     cfg_data,
  output int                              fail_count,
  output int                              pending_count
);
  import npw_pkg::*;

  localparam int TABLE_SLOTS = 1 << SLOT_W;

  typedef struct packed {
    npw_status_t             status;
    logic [LEAF_PAGE_W-1:0]  page;
    logic [SLOT_W-1:0]       slot;
    logic                    valid;
    logic [FRAME_W-1:0]      frame;
  } walk_result_t;

  logic [ENTRY_W-1:0]  entry_mem [0:MEM_DEPTH-1];
  int                  pages_taken;
  logic [FRAME_W-1:0]  base_frame;
  logic [USABLE_W-1:0] usable_pages;
  walk_result_t        walk_results_due [$];

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic predict_walk(input logic op, input logic [ADDR_BITS-1:0] addr,
                              output walk_result_t r);
    int                 page;
    int                 lvl;
    int                 limit;
    int                 pos;
    int                 np;
    logic [SLOT_W-1:0]  idx;
    logic [ENTRY_W-1:0] e;
    logic [FRAME_W-1:0] rel;
    npw_status_t        st;
    page = 0;
    st = ST_OK;
    limit = int'(usable_pages);
    if (limit == 0 || limit > POOL_PAGES) limit = POOL_PAGES;
    for (lvl = 0; lvl < LEVELS - 1 && st == ST_OK; lvl++) begin
      idx = SLOT_W'(addr >> (LEAF_SHIFT + SLOT_W * (LEVELS - 1 - lvl)));
      pos = page * TABLE_SLOTS + int'(idx);
      e = entry_mem[pos];
      if (!e[FRAME_W]) begin
        if (op == OP_FIND) begin
          st = ST_MISSING;
        end else if (pages_taken >= limit) begin
          st = ST_EXHAUSTED;
        end else begin
          np = pages_taken;
          pages_taken++;
          for (int k = 0; k < TABLE_SLOTS; k++) entry_mem[np * TABLE_SLOTS + k] = '0;
          entry_mem[pos] = {1'b1, base_frame + FRAME_W'(np)};
          page = np;
        end
      end else begin
        // link frame relative to the pool base, wrapping at the frame width
        rel = e[FRAME_W-1:0] - base_frame;
        if (rel >= FRAME_W'(pages_taken)) st = ST_MISSING;
        else page = int'(rel);
      end
    end
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      idx = addr[LEAF_SHIFT +: SLOT_W];
      pos = page * TABLE_SLOTS + int'(idx);
      if (op == OP_BUILD) entry_mem[pos] = {1'b1, addr[ADDR_BITS-1:LEAF_SHIFT]};
      r.page  = LEAF_PAGE_W'(page);
      r.slot  = idx;
      r.valid = entry_mem[pos][FRAME_W];
      r.frame = entry_mem[pos][FRAME_W-1:0];
    end
  endtask

  always @(posedge clk) begin
    walk_result_t due;
    walk_result_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < MEM_DEPTH; i++) entry_mem[i] = '0;
      pages_taken  = 1;
      base_frame   = '0;
      usable_pages = USABLE_W'(64);
      walk_results_due.delete();
      pending_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE:   base_frame = cfg_data;
          CFG_USABLE: usable_pages = cfg_data[USABLE_W-1:0];
          default:    ;
        endcase
      end
      // results are checked before this edge's item is queued
      if (out_valid && !out_stall) begin
        if (walk_results_due.size() == 0) begin
          report_mismatch("result item with no walk outstanding");
        end else begin
          due = walk_results_due.pop_front();
          if (out_status !== due.status)
            report_mismatch($sformatf("status got %0d exp %0d", out_status, due.status));
          if (out_leaf_table_page !== due.page)
            report_mismatch($sformatf("leaf_table_page got %0d exp %0d",
                                      out_leaf_table_page, due.page));
          if (out_leaf_slot !== due.slot)
            report_mismatch($sformatf("leaf_slot got %0d exp %0d", out_leaf_slot, due.slot));
          if (out_leaf_valid !== due.valid)
            report_mismatch($sformatf("leaf_valid got %0d exp %0d", out_leaf_valid, due.valid));
          if (out_leaf_frame !== due.frame)
            report_mismatch($sformatf("leaf_frame got %0h exp %0h", out_leaf_frame, due.frame));
        end
      end
      if (in_valid && !in_stall) begin
        predict_walk(in_opcode, in_phys_addr, fresh);
        walk_results_due.push_back(fresh);
      end
      pending_count <= walk_results_due.size();
    end
  end

endmodule

// ----- verif/nested_page_table_walk_build_tb.sv -----
`timescale 1ns / 100ps
// Top of the page table walker testbench: clock, reset, find/build stimulus,
// register writes and result backpressure. Depends on npw_pkg and the checker.
module nested_page_table_walk_build_tb;
  import npw_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 175;
  localparam int PHASES      = 8;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_opcode = OP_FIND;
  logic [ADDR_BITS-1:0]   in_phys_addr = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic [LEAF_PAGE_W-1:0] out_leaf_table_page;
  logic [SLOT_W-1:0]      out_leaf_slot;
  logic                   out_leaf_valid;
  logic [FRAME_W-1:0]     out_leaf_frame;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_BASE;
  logic [FRAME_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int stall_pct = 0;
  int gap_pct = 0;
  logic [ADDR_BITS-1:0] known_addrs [$];

  nested_page_table_walk_build uut (.*);
  nested_page_table_walk_build_chk checker_i (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL nested_page_table_walk_build");
      $finish;
    end
  end

  // leaves valid high when the next item follows at once
  task automatic send_request(input logic op, input logic [ADDR_BITS-1:0] addr);
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_phys_addr <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (known_addrs.size() < 256) known_addrs.push_back(addr);
    else known_addrs[$urandom_range(0, 255)] = addr;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [FRAME_W-1:0] base, input int usable);
    wait_idle();
    write_reg(CFG_BASE, base);
    write_reg(CFG_USABLE, FRAME_W'(usable));
    cfg_valid <= 1'b0;
  endtask

  // mostly addresses that share upper levels with earlier ones, so walks go deep
  function automatic logic [ADDR_BITS-1:0] random_addr();
    logic [ADDR_BITS-1:0] raw;
    logic [ADDR_BITS-1:0] pick;
    raw = ADDR_BITS'({$urandom, $urandom});
    if (known_addrs.size() == 0 || $urandom_range(0, 99) < 15) return raw;
    pick = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
    case ($urandom_range(0, 3))
      0:       return pick;
      1:       return {pick[ADDR_BITS-1:21], raw[20:0]};
      2:       return {pick[ADDR_BITS-1:30], raw[29:0]};
      default: return {pick[ADDR_BITS-1:39], raw[38:0]};
    endcase
  endfunction

  initial begin : result_backpressure
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [FRAME_W-1:0] phase_base [0:PHASES-1];
    int                 phase_usable [0:PHASES-1];
    phase_base   = '{36'h0, 36'h0, 36'h9_8765_4321, 36'h0, 36'h2, 36'h0,
                     36'hF_FFFF_FFFF, 36'h0};
    phase_usable = '{6, 14, 24, 40, 0, 127, 64, 64};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    stall_pct = 30;
    gap_pct   = 30;

    // no page may be handed out with a limit of one
    configure(36'h0, 1);
    send_request(OP_BUILD, 48'h0);
    send_request(OP_FIND, 48'h0);
    send_request(OP_BUILD, 48'hFFFF_FFFF_FFFF);
    // one page left: build runs out after the first level, which stays
    configure(36'h0, 2);
    send_request(OP_BUILD, 48'h0);
    send_request(OP_FIND, 48'h0);
    configure(36'h0, 64);
    send_request(OP_BUILD, 48'h0);
    send_request(OP_FIND, 48'h0);
    send_request(OP_FIND, 48'h0000_0000_1000);
    send_request(OP_BUILD, 48'hFFFF_FFFF_FFFF);
    send_request(OP_FIND, 48'hFFFF_FFFF_FFFF);
    send_request(OP_BUILD, 48'hFFFF_FFFF_FFFF);
    send_request(OP_BUILD, 48'h0000_0000_1FFF);
    send_request(OP_FIND, 48'h8000_0000_0000);
    send_request(OP_FIND, 48'hAAAA_AAAA_AAAA);
    send_request(OP_BUILD, 48'h5555_5555_5555);
    send_request(OP_FIND, 48'h5555_5555_5555);
    // moved pool base breaks the existing links
    configure(36'h1_2345_6789, 64);
    send_request(OP_FIND, 48'h0);
    send_request(OP_BUILD, 48'h0);
    send_request(OP_BUILD, 48'h4000_0000_0000);
    // link frames wrap past the top of the frame range
    configure(36'hF_FFFF_FFFF, 64);
    send_request(OP_BUILD, 48'h2000_0000_0000);
    send_request(OP_FIND, 48'h2000_0000_0000);
    send_request(OP_FIND, 48'h0);
    // usable counts of zero and above the pool size clamp to the pool size
    configure(36'h0, 0);
    send_request(OP_BUILD, 48'h0123_4567_89AB);
    configure(36'h0, 127);
    send_request(OP_FIND, 48'h0123_4567_89AB);

    for (int p = 0; p < PHASES; p++) begin
      configure(phase_base[p], phase_usable[p]);
      gap_pct   = (p == 3 || p == PHASES - 1) ? 0 : 25;
      stall_pct = (p == 5 || p == PHASES - 1) ? 0 : 25;
      repeat (PHASE_ITEMS)
        send_request(($urandom_range(0, 1) != 0) ? OP_BUILD : OP_FIND, random_addr());
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS nested_page_table_walk_build");
    end else begin
      $display("FAIL nested_page_table_walk_build");
    end
    $finish;
  end

endmodule
